// ===== src/i2cra_pkg.sv =====
// package for the i2c register access master
// holds the item field widths, op codes, sequencer steps and shared structs
package i2cra_pkg;

    localparam int DEV_ADDR_W      = 7;
    localparam int PHASE_W         = 10;
    localparam int BYTE_W          = 8;
    localparam int DEV_ADDR_RESET  = 56;
    localparam int PHASE_RESET     = 5;
    localparam int STOP_GUARD_DEF  = 20;
    localparam int GUARD_W         = 8;
    localparam int S_TDATA_W       = 32;
    localparam int M_TDATA_W       = 16;
    localparam int CFG_IDX_W       = 1;
    localparam int QUEUE_DEPTH     = 2;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_PUSH  = 2'd3
    } op_t;

    localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE    = 1'b1;

    typedef enum logic [15:0] {
        ST_IDLE      = 16'h0001,
        ST_START1    = 16'h0002,
        ST_TX_ADDRW  = 16'h0004,
        ST_ACK_ADDRW = 16'h0008,
        ST_TX_REG    = 16'h0010,
        ST_ACK_REG   = 16'h0020,
        ST_START2    = 16'h0040,
        ST_TX_ADDRR  = 16'h0080,
        ST_ACK_ADDRR = 16'h0100,
        ST_RX_DATA   = 16'h0200,
        ST_TXACK     = 16'h0400,
        ST_WAIT_DATA = 16'h0800,
        ST_TX_DATA   = 16'h1000,
        ST_ACK_DATA  = 16'h2000,
        ST_STOP      = 16'h4000,
        ST_GUARD     = 16'h8000
    } step_t;

    // decoded item passed from the front part to the sequencer
    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] reg_addr;
        logic [BYTE_W-1:0] byte_count;
        logic [BYTE_W-1:0] write_data;
        logic              sda_in;
    } cmd_t;

    typedef struct packed {
        logic              scl;
        logic              sda_low;
        logic [BYTE_W-1:0] read_data;
        logic              read_valid;
        logic              read_last;
        logic              want_byte;
        logic              busy_res;
        logic              done_res;
        logic              status;
    } res_t;

endpackage

// ===== src/i2cra_cmd_queue.sv =====
// front part: accepts input items into a short queue ahead of the sequencer
// uses i2cra_pkg for the command struct
module i2cra_cmd_queue
    import i2cra_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd
);

    cmd_t       mem_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'(QUEUE_DEPTH));
    assign out_valid = (count_reg != 2'd0);
    assign out_cmd   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'(QUEUE_DEPTH))
        else $error("queue count overflow");
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd0) |-> !pop)
        else $error("pop from empty queue");
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("queue count did not advance");
`endif

endmodule

// ===== src/i2cra_sequencer.sv =====
// back part: sequencer, one item per cycle unless stalled, one result each
// uses i2cra_pkg for step codes, command and result structs
module i2cra_sequencer
    import i2cra_pkg::*;
#(
    parameter int StopGuardTicks = STOP_GUARD_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [DEV_ADDR_W-1:0] device_address,
    input  logic [PHASE_W-1:0]    phase_ticks,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  cmd_t                  cmd,
    output logic                  res_valid,
    input  logic                  res_ready,
    output res_t                  res
);

    step_t             step_reg, step_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [3:0]        sub_reg, sub_next;
    logic [BYTE_W-1:0] shift_reg, shift_next;
    logic [BYTE_W-1:0] left_reg, left_next;
    logic              is_read_reg, is_read_next;
    logic [BYTE_W-1:0] target_reg, target_next;
    logic [BYTE_W-1:0] hold_reg, hold_next;
    logic              hold_full_reg, hold_full_next;
    logic              status_reg, status_next;
    logic              scl_reg, scl_next;
    logic              sda_reg, sda_next;
    logic              res_valid_reg;
    res_t              res_reg, res_next;

    logic              take;
    logic              done, rvalid, rlast;
    logic [BYTE_W-1:0] rdata;
    logic [PHASE_W-1:0] len;
    logic [3:0]        last;
    logic              busy;

    assign cmd_ready = !res_valid_reg || res_ready;
    assign take      = cmd_valid && cmd_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    function automatic logic [3:0] last_sub(step_t st);
        unique case (st)
            ST_START1, ST_START2: last_sub = 4'd3;
            ST_TX_ADDRW, ST_TX_REG, ST_TX_ADDRR, ST_TX_DATA, ST_RX_DATA: last_sub = 4'd15;
            ST_GUARD: last_sub = 4'd0;
            default: last_sub = 4'd2;
        endcase
    endfunction

    always_comb begin
        step_next      = step_reg;
        phase_next     = phase_reg;
        sub_next       = sub_reg;
        shift_next     = shift_reg;
        left_next      = left_reg;
        is_read_next   = is_read_reg;
        target_next    = target_reg;
        hold_next      = hold_reg;
        hold_full_next = hold_full_reg;
        status_next    = status_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        done   = 1'b0;
        rvalid = 1'b0;
        rlast  = 1'b0;
        rdata  = '0;
        len    = '0;
        last   = last_sub(step_reg);

        if (take) begin
            unique case (cmd.op)
                OP_TICK: begin
                    if (step_reg == ST_WAIT_DATA) begin
                        if (hold_full_reg) begin
                            shift_next     = hold_reg;
                            hold_full_next = 1'b0;
                            left_next      = left_reg - 8'd1;
                            step_next      = ST_TX_DATA;
                            sub_next       = 4'd0;
                            phase_next     = '0;
                        end
                    end else if (step_reg != ST_IDLE) begin
                        if (step_reg == ST_GUARD) begin
                            len = PHASE_W'(StopGuardTicks);
                        end else begin
                            len = (phase_ticks == '0) ? PHASE_W'(1) : phase_ticks;
                        end
                        if ({1'b0, phase_reg} + 11'd1 < {1'b0, len}) begin
                            phase_next = phase_reg + 1'b1;
                        end else begin
                            phase_next = '0;
                            if ((step_reg == ST_ACK_ADDRW || step_reg == ST_ACK_REG ||
                                 step_reg == ST_ACK_ADDRR || step_reg == ST_ACK_DATA) &&
                                sub_reg == 4'd1 && cmd.sda_in) begin
                                status_next = 1'b1;
                            end
                            if (step_reg == ST_RX_DATA && !sub_reg[0]) begin
                                shift_next = {shift_reg[BYTE_W-2:0], cmd.sda_in};
                            end
                            if (sub_reg < last) begin
                                sub_next = sub_reg + 4'd1;
                            end else begin
                                sub_next = 4'd0;
                                unique case (step_reg)
                                    ST_START1: begin
                                        shift_next = {device_address, 1'b0};
                                        step_next  = ST_TX_ADDRW;
                                    end
                                    ST_START2: begin
                                        shift_next = {device_address, 1'b1};
                                        step_next  = ST_TX_ADDRR;
                                    end
                                    ST_TX_ADDRW: step_next = ST_ACK_ADDRW;
                                    ST_TX_REG:   step_next = ST_ACK_REG;
                                    ST_TX_ADDRR: step_next = ST_ACK_ADDRR;
                                    ST_TX_DATA:  step_next = ST_ACK_DATA;
                                    ST_ACK_ADDRW, ST_ACK_REG, ST_ACK_ADDRR,
                                    ST_ACK_DATA: begin
                                        if (status_next) begin
                                            step_next = ST_STOP;
                                        end else if (step_reg == ST_ACK_ADDRW) begin
                                            shift_next = target_reg;
                                            step_next  = ST_TX_REG;
                                        end else if (step_reg == ST_ACK_ADDRR) begin
                                            shift_next = '0;
                                            step_next  = ST_RX_DATA;
                                        end else if (step_reg == ST_ACK_REG && is_read_reg) begin
                                            step_next = ST_START2;
                                        end else if (step_reg == ST_ACK_DATA &&
                                                     left_reg == '0) begin
                                            step_next = ST_STOP;
                                        end else if (hold_full_reg) begin
                                            shift_next     = hold_reg;
                                            hold_full_next = 1'b0;
                                            left_next      = left_reg - 8'd1;
                                            step_next      = ST_TX_DATA;
                                        end else begin
                                            step_next = ST_WAIT_DATA;
                                        end
                                    end
                                    ST_RX_DATA: begin
                                        left_next = left_reg - 8'd1;
                                        rvalid    = 1'b1;
                                        rdata     = shift_next;
                                        rlast     = (left_next == '0);
                                        step_next = ST_TXACK;
                                    end
                                    ST_TXACK: begin
                                        if (left_reg == '0) begin
                                            step_next = ST_STOP;
                                        end else begin
                                            shift_next = '0;
                                            step_next  = ST_RX_DATA;
                                        end
                                    end
                                    ST_STOP: begin
                                        if (StopGuardTicks == 0) begin
                                            done = 1'b1;
                                        end else begin
                                            step_next = ST_GUARD;
                                        end
                                    end
                                    default: done = 1'b1;
                                endcase
                                if (done) begin
                                    step_next = ST_IDLE;
                                    scl_next  = 1'b1;
                                    sda_next  = 1'b1;
                                    if (!is_read_reg) begin
                                        hold_full_next = 1'b0;
                                    end
                                end
                            end
                        end
                    end
                end
                OP_PUSH: begin
                    if (!hold_full_reg) begin
                        hold_next      = cmd.write_data;
                        hold_full_next = 1'b1;
                    end
                end
                default: begin
                    if (step_reg == ST_IDLE) begin
                        target_next  = cmd.reg_addr;
                        left_next    = cmd.byte_count;
                        is_read_next = (cmd.op == OP_READ);
                        status_next  = 1'b0;
                        if (cmd.byte_count == '0) begin
                            done = 1'b1;
                        end else begin
                            step_next  = ST_START1;
                            sub_next   = 4'd0;
                            phase_next = '0;
                        end
                    end
                end
            endcase

            // line levels follow the step just entered or advanced
            if (step_next != step_reg || sub_next != sub_reg) begin
                unique case (step_next)
                    ST_START1, ST_START2: begin
                        if (sub_next == 4'd0) sda_next = 1'b1;
                        else if (sub_next == 4'd1) scl_next = 1'b1;
                        else if (sub_next == 4'd2) sda_next = 1'b0;
                        else scl_next = 1'b0;
                    end
                    ST_TX_ADDRW, ST_TX_REG, ST_TX_ADDRR, ST_TX_DATA: begin
                        sda_next = shift_next[3'(7 - 32'(sub_next[3:1]))];
                        scl_next = !sub_next[0];
                    end
                    ST_ACK_ADDRW, ST_ACK_REG, ST_ACK_ADDRR, ST_ACK_DATA: begin
                        if (sub_next == 4'd0) begin
                            sda_next = 1'b1;
                            scl_next = 1'b0;
                        end else begin
                            scl_next = (sub_next == 4'd1);
                        end
                    end
                    ST_RX_DATA: begin
                        sda_next = 1'b1;
                        scl_next = !sub_next[0];
                    end
                    ST_TXACK: begin
                        if (sub_next == 4'd0) begin
                            sda_next = (left_next == '0);
                            scl_next = 1'b0;
                        end else begin
                            scl_next = (sub_next == 4'd1);
                        end
                    end
                    ST_STOP: begin
                        if (sub_next == 4'd0) begin
                            sda_next = 1'b0;
                            scl_next = 1'b0;
                        end else if (sub_next == 4'd1) begin
                            scl_next = 1'b1;
                        end else begin
                            sda_next = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end

        busy = (step_next != ST_IDLE);
        res_next.scl        = scl_next;
        res_next.sda_low    = !sda_next;
        res_next.read_data  = rdata;
        res_next.read_valid = rvalid;
        res_next.read_last  = rlast;
        res_next.want_byte  = busy && !is_read_next && !hold_full_next && (left_next != '0);
        res_next.busy_res   = busy;
        res_next.done_res   = done;
        res_next.status     = done && status_next;
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            res_reg <= res_next;
        end
        hold_reg <= hold_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= ST_IDLE;
            phase_reg     <= '0;
            sub_reg       <= '0;
            shift_reg     <= '0;
            left_reg      <= '0;
            is_read_reg   <= 1'b0;
            target_reg    <= '0;
            hold_full_reg <= 1'b0;
            status_reg    <= 1'b0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            res_valid_reg <= 1'b0;
        end else begin
            step_reg      <= step_next;
            phase_reg     <= phase_next;
            sub_reg       <= sub_next;
            shift_reg     <= shift_next;
            left_reg      <= left_next;
            is_read_reg   <= is_read_next;
            target_reg    <= target_next;
            hold_full_reg <= hold_full_next;
            status_reg    <= status_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            if (take) begin
                res_valid_reg <= 1'b1;
            end else if (res_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_idle_lines: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg == ST_IDLE) |-> (scl_reg && sda_reg))
        else $error("bus not released while idle");
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && done) |=> (step_reg == ST_IDLE))
        else $error("done without returning to idle");
    a_rx_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && rvalid) |-> is_read_reg)
        else $error("read byte outside a read burst");
`endif

endmodule

// ===== src/i2c_register_access_master.sv =====
// i2c register access master: tick-driven open-drain bus sequencer for
// register burst reads and writes.
// channels: s_ carries items (op, reg_addr, byte_count, write_data, sda_in),
// m_ carries one result item for each input item (line levels, read byte,
// flags); cfg_ writes device_address (index 0) and phase_ticks (index 1).
// an item passes a two-entry command queue, then the sequencer handles it and
// registers the result; one item is taken every cycle when nothing stalls.
// only tick items advance the bus; each bus phase lasts phase_ticks ticks,
// the stop guard lasts StopGuardTicks ticks.
// reset releases both lines, empties queue and result register and loads
// device_address 56 and phase_ticks 5.
// when m_tready is low the result register holds, the sequencer stops and
// the queue fills, after which s_tready falls; nothing is lost.
// depends on i2cra_pkg, i2cra_cmd_queue and i2cra_sequencer
module i2c_register_access_master
    import i2cra_pkg::*;
#(
    parameter int StopGuardTicks = STOP_GUARD_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // tdata: reg_addr[7:0], byte_count[15:8], write_data[23:16], sda_in[24], zeros
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // tuser: op[1:0]
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // tdata: scl[0], sda_low[1], read_data[9:2], want_byte[10], busy_res[11],
    // done_res[12], status[13], zeros
    output logic [M_TDATA_W-1:0]  m_tdata,
    // tuser: read_valid
    output logic                  m_tuser,
    // tlast: read_last
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [PHASE_W-1:0]    cfg_data
);

    logic [DEV_ADDR_W-1:0] dev_addr_reg;
    logic [PHASE_W-1:0]    phase_ticks_reg;
    cmd_t                  in_cmd, q_cmd;
    logic                  q_valid, q_ready;
    res_t                  res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg    <= DEV_ADDR_W'(DEV_ADDR_RESET);
            phase_ticks_reg <= PHASE_W'(PHASE_RESET);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_DEV_ADDR: dev_addr_reg    <= cfg_data[DEV_ADDR_W-1:0];
                CFG_PHASE:    phase_ticks_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        in_cmd.op         = op_t'(s_tuser);
        in_cmd.reg_addr   = s_tdata[7:0];
        in_cmd.byte_count = s_tdata[15:8];
        in_cmd.write_data = s_tdata[23:16];
        in_cmd.sda_in     = s_tdata[24];
    end

    i2cra_cmd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (in_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    i2cra_sequencer #(
        .StopGuardTicks (StopGuardTicks)
    ) u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .device_address (dev_addr_reg),
        .phase_ticks    (phase_ticks_reg),
        .cmd_valid      (q_valid),
        .cmd_ready      (q_ready),
        .cmd            (q_cmd),
        .res_valid      (m_tvalid),
        .res_ready      (m_tready),
        .res            (res)
    );

    assign m_tdata = {2'b00, res.status, res.done_res, res.busy_res, res.want_byte,
                      res.read_data, res.sda_low, res.scl};
    assign m_tuser = res.read_valid;
    assign m_tlast = res.read_last;

endmodule
